FILE: rtl/acsi_pkg.sv
// Shared types and character constants of the ANSI CSI escape parser.
package acsi_pkg;

   localparam int CUR_W = 16;
   localparam int DEC_BASE = 10;

   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_H = 8'h48;
   localparam logic [7:0] CH_0 = 8'h30;
   localparam logic [7:0] CH_9 = 8'h39;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_ESC = 2'd1;
   localparam logic [1:0] PH_ARGS = 2'd2;

   localparam logic KIND_PRINT = 1'b0;
   localparam logic KIND_CURSOR = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIGIT = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_EMIT  = 4'b1000
   } seq_state_type;

   typedef struct packed {
      logic             kind;
      logic [7:0]       print_char;
      logic [CUR_W-1:0] cursor_x;
      logic             x_present;
      logic [CUR_W-1:0] cursor_y;
      logic             y_present;
   } result_type;

endpackage

FILE: rtl/ansi_csi_escape_parser_top.sv
// Top level of the ANSI CSI escape parser with its argument memory and sequencer.
//
//   channel | direction | ports                                   | carries
//   req     | in        | req_valid, req_ready, req_in_byte       | one stream byte
//   rsp     | out       | rsp_valid, rsp_ready, rsp_kind, ...     | print or cursor item
//
// A byte that prints passes through the emit state, a digit reads its slot and then writes
// it back, and any other byte is taken in the idle state alone. A final 'H' walks the
// argument slots through the memory read port until it finds a Y value or reaches the last
// slot written, and then emits its cursor item.
// Reset puts the parser in its idle phase; the argument memory needs no clearing.
// A result waits in the output register while the next byte is parsed; only a new
// result stalls until that register is free.
module ansi_csi_escape_parser_top #(
   parameter int ARG_SLOTS = 8,
   parameter int ARG_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_print_char,
   output logic [15:0] rsp_cursor_x,
   output logic        rsp_x_present,
   output logic [15:0] rsp_cursor_y,
   output logic        rsp_y_present
);

   localparam int IDX_W = $clog2(ARG_SLOTS + 1);
   localparam int ENT_W = ARG_BITS + 1;
   localparam int PRD_W = ARG_BITS + 4;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ARG_SLOTS);

   acsi_pkg::seq_state_type state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [IDX_W-1:0]  lim_ff, lim_in;
   logic [3:0]        dig_ff, dig_in;
   acsi_pkg::result_type res_ff, res_in;
   acsi_pkg::result_type out_ff, out_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [ENT_W-1:0]  arg_mem_ff [ARG_SLOTS+1];
   logic [ENT_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ENT_W-1:0]  wr_data;

   logic              accept;
   logic              is_digit;
   logic [IDX_W-1:0]  idx_next;
   logic              rd_empty;
   logic [ARG_BITS-1:0] rd_val;
   logic [PRD_W-1:0]  prod;
   logic              sat;
   logic [ENT_W-1:0]  clear_ent;

   assign req_ready = (state_ff == acsi_pkg::ST_IDLE);
   assign accept = req_valid && req_ready;
   assign is_digit = (req_in_byte >= acsi_pkg::CH_0) && (req_in_byte <= acsi_pkg::CH_9);
   assign idx_next = (idx_ff < LAST_SLOT) ? idx_ff + IDX_W'(1) : idx_ff;
   assign rd_empty = rd_data_ff[ARG_BITS];
   assign rd_val = rd_data_ff[ARG_BITS-1:0];
   assign prod = PRD_W'(rd_val) * PRD_W'(acsi_pkg::DEC_BASE) + PRD_W'(dig_ff);
   assign sat = |prod[PRD_W-1:ARG_BITS];
   assign clear_ent = {1'b1, {ARG_BITS{1'b0}}};

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      idx_in = idx_ff;
      scan_in = scan_ff;
      lim_in = lim_ff;
      dig_in = dig_ff;
      res_in = res_ff;
      out_in = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = clear_ent;
      case (state_ff)
         acsi_pkg::ST_IDLE: begin
            if (accept) begin
               case (phase_ff)
                  acsi_pkg::PH_ESC: begin
                     if (req_in_byte == acsi_pkg::CH_LBRACKET) begin
                        phase_in = acsi_pkg::PH_ARGS;
                     end else begin
                        phase_in = acsi_pkg::PH_IDLE;
                        res_in = '0;
                        res_in.kind = acsi_pkg::KIND_PRINT;
                        res_in.print_char = req_in_byte;
                        state_in = acsi_pkg::ST_EMIT;
                     end
                  end
                  acsi_pkg::PH_ARGS: begin
                     if (is_digit) begin
                        rd_addr = idx_ff;
                        dig_in = 4'(req_in_byte - acsi_pkg::CH_0);
                        state_in = acsi_pkg::ST_DIGIT;
                     end else begin
                        idx_in = idx_next;
                        wr_en = 1'b1;
                        wr_addr = idx_next;
                        if (req_in_byte != acsi_pkg::CH_SEMI) begin
                           phase_in = acsi_pkg::PH_IDLE;
                           if (req_in_byte == acsi_pkg::CH_H) begin
                              lim_in = idx_next;
                              scan_in = '0;
                              rd_addr = '0;
                              res_in = '0;
                              res_in.kind = acsi_pkg::KIND_CURSOR;
                              state_in = acsi_pkg::ST_SCAN;
                           end
                        end
                     end
                  end
                  default: begin
                     if (req_in_byte == acsi_pkg::CH_ESC) begin
                        phase_in = acsi_pkg::PH_ESC;
                        idx_in = '0;
                        wr_en = 1'b1;
                        wr_addr = '0;
                     end else begin
                        phase_in = acsi_pkg::PH_IDLE;
                        res_in = '0;
                        res_in.kind = acsi_pkg::KIND_PRINT;
                        res_in.print_char = req_in_byte;
                        state_in = acsi_pkg::ST_EMIT;
                     end
                  end
               endcase
            end
         end
         acsi_pkg::ST_DIGIT: begin
            wr_en = 1'b1;
            wr_addr = idx_ff;
            wr_data = {1'b0, sat ? {ARG_BITS{1'b1}} : prod[ARG_BITS-1:0]};
            state_in = acsi_pkg::ST_IDLE;
         end
         acsi_pkg::ST_SCAN: begin
            if (scan_ff == lim_ff) begin
               state_in = acsi_pkg::ST_EMIT;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
               rd_addr = scan_ff + IDX_W'(1);
               if (!rd_empty) begin
                  if (!res_ff.x_present) begin
                     res_in.cursor_x = acsi_pkg::CUR_W'(rd_val);
                     res_in.x_present = 1'b1;
                  end else begin
                     res_in.cursor_y = acsi_pkg::CUR_W'(rd_val);
                     res_in.y_present = 1'b1;
                     state_in = acsi_pkg::ST_EMIT;
                  end
               end
            end
         end
         acsi_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = acsi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = acsi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= acsi_pkg::ST_IDLE;
         phase_ff <= acsi_pkg::PH_IDLE;
         idx_ff <= '0;
         scan_ff <= '0;
         lim_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         idx_ff <= idx_in;
         scan_ff <= scan_in;
         lim_ff <= lim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff <= dig_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         arg_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= arg_mem_ff[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = out_ff.kind;
   assign rsp_print_char = out_ff.print_char;
   assign rsp_cursor_x = out_ff.cursor_x;
   assign rsp_x_present = out_ff.x_present;
   assign rsp_cursor_y = out_ff.cursor_y;
   assign rsp_y_present = out_ff.y_present;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_SLOT)
      else $error("Argument index ran past the last slot.");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == acsi_pkg::ST_SCAN) |-> (scan_ff <= lim_ff && !wr_en))
      else $error("Slot walk overran its limit or wrote the memory.");

   a_y_needs_x: assert property (@(posedge clock) disable iff (reset)
      (state_ff == acsi_pkg::ST_EMIT && res_ff.y_present) |-> res_ff.x_present)
      else $error("Cursor Y present without X.");

   a_h_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == acsi_pkg::PH_ARGS && req_in_byte == acsi_pkg::CH_H)
      |=> (state_ff == acsi_pkg::ST_SCAN && phase_ff == acsi_pkg::PH_IDLE))
      else $error("Final H did not start the slot walk.");

   a_digit_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == acsi_pkg::ST_DIGIT) |-> (wr_en && wr_addr == idx_ff
         && $past(accept)))
      else $error("Digit update did not write back its own slot.");

endmodule
